// ===== src/sstr_pkg.sv =====
package sstr_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_PHASE_STEP   = 3'd0;
    localparam logic [2:0] REG_AMPLITUDE    = 3'd1;
    localparam logic [2:0] REG_LEFT_GAIN    = 3'd2;
    localparam logic [2:0] REG_RIGHT_GAIN   = 3'd3;
    localparam logic [2:0] REG_DELAY_FRAMES = 3'd4;
    localparam logic [2:0] REG_DELAYED_SIDE = 3'd5;

    // Delayed side codes; the spare code means no delay.
    localparam logic [1:0] SIDE_NONE  = 2'd0;
    localparam logic [1:0] SIDE_LEFT  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT = 2'd2;

    // Register reset values.
    localparam logic [31:0] PHASE_STEP_RST = 32'd39370534;
    localparam logic [14:0] AMPLITUDE_RST  = 15'd3277;
    localparam logic [14:0] GAIN_RST       = 15'd23170;

    // Word width shared by the amplitude and both channel gains.
    localparam int GAIN_W = 15;

    // Quarter turn in Q30 and the Taylor series denominators (2n)(2n+1).
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned SINE_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // One quarter-wave table entry, evaluated at elaboration time.
    function automatic longint unsigned sine_entry(input int k, input int table_bits,
                                                   input int sample_width);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned smax;
        longint unsigned v;
        x    = (HALF_PI_Q30 * longint'(k)) >> table_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        smax = (64'd1 << (sample_width - 1)) - 64'd1;
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / SINE_DIV[n - 1];
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (longint'(sum) * smax + (64'd1 << 29)) >> 30;
        if (v > smax) begin
            v = smax;
        end
        return v;
    endfunction

endpackage

// ===== src/spatial_sine_tone_renderer_unit.sv =====
// A frame accepted in the idle state steps through AMP, CUR, LEFT, RIGHT and DONE; o_valid
// rises as DONE hands the result to the output register. No new frame is taken until the unit
// is idle again, as the single multiplier is used in turn for amplitude, left gain and right gain.
// A transaction with frame_tick low is accepted in the idle state and gives no result.
// Reset (synchronous, active low) clears phase, write pointer and fill count and
// loads register defaults; delay entries not yet written read as zero.
module spatial_sine_tone_renderer_unit import sstr_pkg::*; #(
    parameter int DELAY_DEPTH     = 64,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_WIDTH    = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [2:0]                     i_cfg_index,
    input  logic [31:0]                    i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_frame_tick,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SAMPLE_WIDTH-1:0] o_left_sample,
    output logic signed [SAMPLE_WIDTH-1:0] o_right_sample
);

    localparam int AW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
    localparam int FW = $clog2(DELAY_DEPTH + 1);
    localparam int DW = (AW > 6) ? AW : 6;
    localparam int TB = SINE_TABLE_BITS;
    localparam int SW = SAMPLE_WIDTH;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_AMP   = 3'd1;
    localparam logic [2:0] ST_CUR   = 3'd2;
    localparam logic [2:0] ST_LEFT  = 3'd3;
    localparam logic [2:0] ST_RIGHT = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // Configuration registers.
    logic [31:0]       r_phase_step;
    logic [GAIN_W-1:0] r_amplitude;
    logic [GAIN_W-1:0] r_left_gain;
    logic [GAIN_W-1:0] r_right_gain;
    logic [5:0]        r_delay_frames;
    logic [1:0]        r_delayed_side;

    // Control state.
    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [31:0]   r_phase;
    logic [AW-1:0] r_wp;
    logic [FW-1:0] r_fill;
    logic          r_out_valid;

    // Working registers of one frame.
    logic                 r_neg;
    logic                 r_d_zero;
    logic                 r_old_valid;
    logic signed [SW-1:0] r_cur;
    logic signed [SW-1:0] r_left;
    logic signed [SW-1:0] r_out_left;
    logic signed [SW-1:0] r_out_right;

    logic                 accept;
    logic                 start;
    logic                 out_load;
    logic [TB-1:0]        quarter_idx;
    logic [TB:0]          rom_addr;
    logic [SW-2:0]        rom_data;
    logic signed [SW-1:0] sine;
    logic [DW-1:0]        d_ext;
    logic [DW-1:0]        d_sat;
    logic [AW-1:0]        d_a;
    logic [AW-1:0]        rd_addr;
    logic                 old_valid;
    logic [SW-1:0]        ram_q;
    logic signed [SW-1:0] delayed;
    logic                 mul_load;
    logic signed [SW-1:0] mul_a;
    logic [GAIN_W-1:0]    mul_b;
    logic                 mul_shift15;
    logic signed [SW-1:0] mul_result;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign start    = accept && i_frame_tick;
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_ready);

    // Configuration writes; out-of-range indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step   <= PHASE_STEP_RST;
            r_amplitude    <= AMPLITUDE_RST;
            r_left_gain    <= GAIN_RST;
            r_right_gain   <= GAIN_RST;
            r_delay_frames <= 6'd0;
            r_delayed_side <= SIDE_NONE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_PHASE_STEP:   r_phase_step   <= i_cfg_data;
                REG_AMPLITUDE:    r_amplitude    <= i_cfg_data[GAIN_W-1:0];
                REG_LEFT_GAIN:    r_left_gain    <= i_cfg_data[GAIN_W-1:0];
                REG_RIGHT_GAIN:   r_right_gain   <= i_cfg_data[GAIN_W-1:0];
                REG_DELAY_FRAMES: r_delay_frames <= i_cfg_data[5:0];
                REG_DELAYED_SIDE: r_delayed_side <= i_cfg_data[1:0];
                default: begin
                end
            endcase
        end
    end

    // Quarter-wave addressing: odd quadrants mirror the index.
    assign quarter_idx = r_phase[29 -: TB];
    assign rom_addr    = r_phase[30] ? ((TB + 1)'(1 << TB) - {1'b0, quarter_idx})
                                     : {1'b0, quarter_idx};

    sstr_sine_rom #(
        .TABLE_BITS   (TB),
        .SAMPLE_WIDTH (SW)
    ) u_rom (
        .i_clk   (i_clk),
        .i_rd_en (start),
        .i_addr  (rom_addr),
        .o_data  (rom_data)
    );

    assign sine = r_neg ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});

    // Read address of the delayed sample, with the delay held below the depth.
    always_comb begin
        d_ext   = DW'(r_delay_frames);
        d_sat   = (d_ext > DW'(DELAY_DEPTH - 1)) ? DW'(DELAY_DEPTH - 1) : d_ext;
        d_a     = d_sat[AW-1:0];
        rd_addr = (r_wp >= d_a) ? (r_wp - d_a) : (r_wp + AW'(DELAY_DEPTH) - d_a);
    end

    // An entry holds data once the fill count has passed it; otherwise it reads zero.
    assign old_valid = (r_fill == FW'(DELAY_DEPTH)) || (FW'(rd_addr) < r_fill);

    sstr_ram #(
        .WIDTH (SW),
        .DEPTH (DELAY_DEPTH)
    ) u_delay (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == ST_CUR),
        .i_wr_addr (r_wp),
        .i_wr_data (mul_result),
        .i_rd_en   (start),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    // A zero delay forwards the current sample.
    always_comb begin
        if (r_d_zero) begin
            delayed = r_cur;
        end else if (r_old_valid) begin
            delayed = $signed(ram_q);
        end else begin
            delayed = '0;
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_load    = 1'b0;
        mul_a       = r_cur;
        mul_b       = r_left_gain;
        mul_shift15 = 1'b1;
        unique case (r_state)
            ST_AMP: begin
                mul_load    = 1'b1;
                mul_a       = sine;
                mul_b       = r_amplitude;
                mul_shift15 = 1'b0;
            end
            ST_LEFT: begin
                mul_load = 1'b1;
                mul_a    = (r_delayed_side == SIDE_LEFT) ? delayed : r_cur;
                mul_b    = r_left_gain;
            end
            ST_RIGHT: begin
                mul_load = 1'b1;
                mul_a    = (r_delayed_side == SIDE_RIGHT) ? delayed : r_cur;
                mul_b    = r_right_gain;
            end
            default: begin
            end
        endcase
    end

    sstr_mul #(
        .SAMPLE_WIDTH (SW)
    ) u_mul (
        .i_clk     (i_clk),
        .i_load    (mul_load),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .i_shift15 (mul_shift15),
        .o_result  (mul_result)
    );

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_AMP;
            ST_AMP:   n_state = ST_CUR;
            ST_CUR:   n_state = ST_LEFT;
            ST_LEFT:  n_state = ST_RIGHT;
            ST_RIGHT: n_state = ST_DONE;
            ST_DONE:  if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control registers: state, phase, pointer, fill count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_wp        <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (start) begin
                r_phase <= r_phase + r_phase_step;
            end
            if (out_load) begin
                r_wp <= (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                if (r_fill != FW'(DELAY_DEPTH)) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Frame data registers.
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_neg       <= r_phase[31];
            r_d_zero    <= (d_a == '0);
            r_old_valid <= old_valid;
        end
        if (r_state == ST_CUR) begin
            r_cur <= mul_result;
        end
        if (r_state == ST_RIGHT) begin
            r_left <= mul_result;
        end
        if (out_load) begin
            r_out_left  <= r_left;
            r_out_right <= mul_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_left_sample  = r_out_left;
    assign o_right_sample = r_out_right;

endmodule

// ===== src/sstr_ram.sv =====
module sstr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/sstr_sine_rom.sv =====
module sstr_sine_rom import sstr_pkg::*; #(
    parameter int TABLE_BITS   = 10,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rd_en,
    input  logic [TABLE_BITS:0]     i_addr,
    output logic [SAMPLE_WIDTH-2:0] o_data
);

    localparam int N = 1 << TABLE_BITS;

    typedef logic [SAMPLE_WIDTH-2:0] t_word;
    typedef t_word t_rom [N + 1];

    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k <= N; k++) begin
            rom[k] = t_word'(sine_entry(k, TABLE_BITS, SAMPLE_WIDTH));
        end
        return rom;
    endfunction

    localparam t_rom ROM = build_rom();

    logic [SAMPLE_WIDTH-2:0] r_data;

    // Registered read of the quarter-wave table. Addresses past N never occur.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= (i_addr > (TABLE_BITS + 1)'(N)) ? ROM[N] : ROM[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

// ===== src/sstr_mul.sv =====
module sstr_mul import sstr_pkg::*; #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_load,
    input  logic signed [SAMPLE_WIDTH-1:0] i_a,
    input  logic        [GAIN_W-1:0]       i_b,
    input  logic                           i_shift15,
    output logic signed [SAMPLE_WIDTH-1:0] o_result
);

    localparam int PW = SAMPLE_WIDTH + GAIN_W + 1;

    localparam logic signed [PW:0] SMAX_W = (PW + 1)'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [PW:0] SMIN_W = -SMAX_W - (PW + 1)'(1);

    logic signed [PW-1:0] r_prod;
    logic                 r_shift15;
    logic signed [PW:0]   rounded;
    logic signed [PW:0]   shifted;

    // The product is registered; rounding and saturation follow in the next cycle.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod    <= i_a * $signed({1'b0, i_b});
            r_shift15 <= i_shift15;
        end
    end

    // Round half up, then shift arithmetically by 14 or 15 bits.
    always_comb begin
        rounded = {r_prod[PW-1], r_prod} +
                  (r_shift15 ? (PW + 1)'(1 << 14) : (PW + 1)'(1 << 13));
        shifted = r_shift15 ? (rounded >>> 15) : (rounded >>> 14);
    end

    // Clamp to the sample range.
    always_comb begin
        if (shifted > SMAX_W) begin
            o_result = SMAX_W[SAMPLE_WIDTH-1:0];
        end else if (shifted < SMIN_W) begin
            o_result = SMIN_W[SAMPLE_WIDTH-1:0];
        end else begin
            o_result = shifted[SAMPLE_WIDTH-1:0];
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sstr_pkg::*;

    localparam int LUT_BITS      = 10;
    localparam int LUT_N         = 1 << LUT_BITS;
    localparam int LINE_DEPTH    = 64;
    localparam int SAMPLE_MAX    = 32767;
    localparam int SAMPLE_MIN    = -32768;
    localparam int GAP_MAX       = 11;
    localparam int LONG_STALL    = 150;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_FRAMES  = 104;

    // Register indexes past the last register; writes to them must be ignored.
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } t_stereo;

    typedef enum logic {ROW_CFG, ROW_FRAME} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic [2:0]  index;
        logic [31:0] data;
        logic        tick;
        bit          fixed;
        t_stereo     want;
    } t_stim_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic        i_frame_tick;
    logic        o_valid;
    logic        i_ready;
    logic signed [15:0] o_left_sample;
    logic signed [15:0] o_right_sample;

    spatial_sine_tone_renderer_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_frame_tick   (i_frame_tick),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_left_sample  (o_left_sample),
        .o_right_sample (o_right_sample)
    );

    // Tone generator state and register copy used for prediction.
    int                 sine_lut [0:LUT_N];
    logic [31:0]        phase_acc;
    logic signed [15:0] tone_line [LINE_DEPTH];
    logic [5:0]         wr_ptr;
    logic [31:0]        phase_step_q;
    logic [14:0]        amplitude_q;
    logic [14:0]        left_gain_q;
    logic [14:0]        right_gain_q;
    logic [5:0]         delay_q;
    logic [1:0]         side_q;

    t_stereo   stereo_due [$];
    t_stim_row plan [$];

    int tx_gap_max;
    int rx_gap_max;
    bit stall_request;
    int frames_sent;
    int silent_sent;
    int results_seen;
    int reg_writes;
    int mismatches;
    int cycle_count;

    // One quarter-wave entry: integer Taylor series of sin in Q30, scaled to the sample range.
    function automatic int quarter_wave(int k);
        t_u64   x;
        t_u64   x2;
        t_u64   term;
        t_u64   v;
        longint acc;
        x    = (HALF_PI_Q30 * t_u64'(k)) >> LUT_BITS;
        x2   = (x * x) >> 30;
        term = x;
        acc  = longint'(x);
        for (int n = 1; n <= 8; n++) begin
            term = ((term * x2) >> 30) / t_u64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        v = (t_u64'(acc) * t_u64'(SAMPLE_MAX) + (t_u64'(1) << 29)) >> 30;
        if (v > t_u64'(SAMPLE_MAX)) begin
            v = t_u64'(SAMPLE_MAX);
        end
        return int'(v);
    endfunction

    // Quadrant folding of the quarter table: the top two index bits pick mirror and sign.
    function automatic longint sine_of(logic [31:0] ph);
        logic [11:0] idx;
        logic [9:0]  ofs;
        longint      v;
        idx = ph[31:20];
        ofs = idx[9:0];
        v   = idx[10] ? longint'(sine_lut[LUT_N - int'(ofs)]) : longint'(sine_lut[ofs]);
        return idx[11] ? -v : v;
    endfunction

    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > SAMPLE_MAX) begin
            return 16'sh7FFF;
        end
        if (v < SAMPLE_MIN) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    task automatic reset_prediction();
        phase_acc    = '0;
        wr_ptr       = '0;
        foreach (tone_line[k]) begin
            tone_line[k] = '0;
        end
        phase_step_q = PHASE_STEP_RST;
        amplitude_q  = AMPLITUDE_RST;
        left_gain_q  = GAIN_RST;
        right_gain_q = GAIN_RST;
        delay_q      = '0;
        side_q       = SIDE_NONE;
    endtask

    // Register writes truncate to the register width; spare indexes change nothing.
    task automatic apply_register(logic [2:0] idx, logic [31:0] data);
        case (idx)
            REG_PHASE_STEP:   phase_step_q = data;
            REG_AMPLITUDE:    amplitude_q  = data[14:0];
            REG_LEFT_GAIN:    left_gain_q  = data[14:0];
            REG_RIGHT_GAIN:   right_gain_q = data[14:0];
            REG_DELAY_FRAMES: delay_q      = data[5:0];
            REG_DELAYED_SIDE: side_q       = data[1:0];
            default: ;
        endcase
    endtask

    // Render one stereo frame and advance phase, delay line and write pointer.
    function automatic t_stereo render_frame();
        longint     s;
        longint     cur;
        longint     sl;
        longint     sr;
        logic [5:0] rd;
        t_stereo    res;
        s         = sine_of(phase_acc);
        phase_acc = phase_acc + phase_step_q;
        cur       = clamp16(round_shift(s * longint'(amplitude_q), 14));
        tone_line[wr_ptr] = cur[15:0];
        rd = wr_ptr - delay_q;
        sl = cur;
        sr = cur;
        if (side_q == SIDE_LEFT) begin
            sl = tone_line[rd];
        end else if (side_q == SIDE_RIGHT) begin
            sr = tone_line[rd];
        end
        res.left  = clamp16(round_shift(sl * longint'(left_gain_q), 15));
        res.right = clamp16(round_shift(sr * longint'(right_gain_q), 15));
        wr_ptr    = wr_ptr + 6'd1;
        return res;
    endfunction

    // Configuration values: extremes, raw words that test masking, or in-range values.
    function automatic logic [31:0] draw_word(logic [31:0] top);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return top;
            2:       return $urandom();
            default: return $urandom_range(0, top);
        endcase
    endfunction

    task automatic add_cfg(logic [2:0] idx, logic [31:0] data);
        plan.push_back('{ROW_CFG, idx, data, 1'b0, 1'b0, '0});
    endtask

    task automatic add_frame(logic tick);
        plan.push_back('{ROW_FRAME, '0, '0, tick, 1'b0, '0});
    endtask

    task automatic add_fixed(logic signed [15:0] l, logic signed [15:0] r);
        plan.push_back('{ROW_FRAME, '0, '0, 1'b1, 1'b1, '{l, r}});
    endtask

    // Offer one frame transaction after a random gap and record its prediction on acceptance.
    task automatic send_frame(logic tick, bit fixed, t_stereo want);
        int      gap;
        t_stereo got;
        gap = $urandom_range(0, tx_gap_max);
        repeat (gap) @(negedge i_clk) i_valid <= 1'b0;
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_frame_tick <= tick;
        do @(posedge i_clk); while (!o_ready);
        frames_sent++;
        if (tick) begin
            got = render_frame();
            stereo_due.push_back(fixed ? want : got);
        end else begin
            silent_sent++;
        end
    endtask

    // Stop offering frames, wait for every pending result, then let the pipeline empty.
    task automatic settle();
        @(negedge i_clk) i_valid <= 1'b0;
        while (stereo_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        apply_register(idx, data);
        reg_writes++;
        @(negedge i_clk) i_cfg_wr_en <= 1'b0;
    endtask

    task automatic program_random_setting();
        write_register(REG_PHASE_STEP, draw_word(32'hFFFF_FFFF));
        write_register(REG_AMPLITUDE, draw_word(32'h0000_7FFF));
        write_register(REG_LEFT_GAIN, draw_word(32'h0000_7FFF));
        write_register(REG_RIGHT_GAIN, draw_word(32'h0000_7FFF));
        write_register(REG_DELAY_FRAMES, draw_word(32'h0000_003F));
        write_register(REG_DELAYED_SIDE, draw_word(32'h0000_0003));
        if ($urandom_range(0, 2) == 0) begin
            write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, $urandom());
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("run limit of %0d cycles reached with %0d results pending",
                   CYCLE_LIMIT, stereo_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Result side: random ready gaps, plus one long hold-off on request.
    initial begin : result_sink
        int gap;
        i_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = $urandom_range(0, rx_gap_max);
            if (stall_request) begin
                gap           = LONG_STALL;
                stall_request = 1'b0;
            end
            repeat (gap) @(negedge i_clk) i_ready <= 1'b0;
            @(negedge i_clk) i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Compare each accepted result transaction with the oldest predicted frame.
    always @(posedge i_clk) begin : result_check
        t_stereo want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (stereo_due.size() == 0) begin
                $error("unexpected result left=%0d right=%0d", o_left_sample, o_right_sample);
                mismatches++;
            end else begin
                want = stereo_due.pop_front();
                if (o_left_sample !== want.left) begin
                    $error("left_sample expected %0d actual %0d", want.left, o_left_sample);
                    mismatches++;
                end
                if (o_right_sample !== want.right) begin
                    $error("right_sample expected %0d actual %0d", want.right, o_right_sample);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        logic tick;
        for (int k = 0; k <= LUT_N; k++) begin
            sine_lut[k] = quarter_wave(k);
        end
        reset_prediction();
        frames_sent   = 0;
        silent_sent   = 0;
        results_seen  = 0;
        reg_writes    = 0;
        mismatches    = 0;
        cycle_count   = 0;
        stall_request = 1'b0;
        tx_gap_max    = 3;
        rx_gap_max    = 3;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_frame_tick  = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: reset state, silent tick, saturation, delay corners, masking.
        add_fixed(16'sd0, 16'sd0);
        add_frame(1'b0);
        add_frame(1'b1);
        add_frame(1'b1);
        add_cfg(REG_AMPLITUDE, 32'd0);
        add_fixed(16'sd0, 16'sd0);
        add_cfg(REG_AMPLITUDE, 32'hFFFF_FFFF);
        add_cfg(REG_PHASE_STEP, 32'h4000_0000);
        repeat (4) add_frame(1'b1);
        add_cfg(REG_LEFT_GAIN, 32'h0000_7FFF);
        add_cfg(REG_RIGHT_GAIN, 32'd0);
        repeat (2) add_frame(1'b1);
        add_cfg(REG_DELAYED_SIDE, {30'd0, SIDE_LEFT});
        add_cfg(REG_DELAY_FRAMES, 32'd0);
        add_frame(1'b1);
        add_cfg(REG_RIGHT_GAIN, 32'h0000_7FFF);
        add_cfg(REG_DELAY_FRAMES, 32'h0000_00FF);
        add_cfg(REG_DELAYED_SIDE, {30'd0, SIDE_RIGHT});
        repeat (2) add_frame(1'b1);
        add_cfg(REG_DELAYED_SIDE, 32'hFFFF_FFFF);
        add_frame(1'b1);
        add_cfg(CFG_SPARE_A, 32'hFFFF_FFFF);
        add_cfg(CFG_SPARE_B, 32'h0000_0000);
        add_frame(1'b1);
        add_cfg(REG_LEFT_GAIN, 32'd0);
        add_cfg(REG_RIGHT_GAIN, 32'hFFFF_8000);
        add_fixed(16'sd0, 16'sd0);
        add_cfg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        add_cfg(REG_LEFT_GAIN, 32'h0000_7FFF);
        add_cfg(REG_RIGHT_GAIN, 32'h0000_7FFF);
        repeat (2) add_frame(1'b1);

        foreach (plan[r]) begin
            if (plan[r].kind == ROW_CFG) begin
                settle();
                write_register(plan[r].index, plan[r].data);
            end else begin
                send_frame(plan[r].tick, plan[r].fixed, plan[r].want);
            end
        end

        // Random part: a fresh setting per phase, mostly real ticks, varied idling.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            program_random_setting();
            tx_gap_max = (ph % 3 == 1) ? 0 : GAP_MAX;
            rx_gap_max = (ph % 4 == 2) ? 0 : GAP_MAX;
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                if (ph == 3 && n == 20) begin
                    stall_request = 1'b1;
                end
                if (ph == 5 && n == 50) begin
                    settle();
                end
                tick = ($urandom_range(0, 9) != 0);
                send_frame(tick, 1'b0, '0);
            end
        end

        settle();
        $display("Sent %0d frame transactions (%0d silent ticks) over %0d register writes;",
                 frames_sent, silent_sent, reg_writes);
        $display("checked %0d stereo results, %0d field mismatches.", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
